### src/rcpd_pkg.sv
`default_nettype none

package rcpd_pkg;

    // Widths of the pulse measurements and of the duty values.
    localparam int WIDTH_BITS = 16;
    localparam int DUTY_BITS  = 8;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

    // The scaled numerator w * DUTY_MAX needs DUTY_BITS more bits than the width.
    localparam int REM_BITS = WIDTH_BITS + DUTY_BITS;

    // One quotient bit more than the duty: it flags a saturated forward duty.
    localparam int QUOT_BITS = DUTY_BITS + 1;

    // Calibration register map: two channels of four registers each.
    localparam int NUM_CHANNELS = 2;
    localparam int REGS_PER_CH  = 4;
    localparam int NUM_REGS     = NUM_CHANNELS * REGS_PER_CH;
    localparam int INDEX_BITS   = $clog2(NUM_REGS);

    localparam int OFS_PULSE_MIN = 0;
    localparam int OFS_PULSE_MAX = 1;
    localparam int OFS_DEAD_LOW  = 2;
    localparam int OFS_DEAD_HIGH = 3;

    localparam int CH_A = 0;
    localparam int CH_B = 1;

    typedef logic [WIDTH_BITS-1:0] width_t;
    typedef logic [DUTY_BITS-1:0]  duty_t;

    localparam width_t CAL_RESET [NUM_REGS] = '{
        WIDTH_BITS'(1131), WIDTH_BITS'(2030), WIDTH_BITS'(1479), WIDTH_BITS'(1485),
        WIDTH_BITS'(970),  WIDTH_BITS'(1850), WIDTH_BITS'(1479), WIDTH_BITS'(1485)
    };

    // What a channel does with its width once it has been placed against the band.
    typedef enum logic [2:0] {
        MODE_IDLE,      // inside the dead band: both pins low
        MODE_REV_FULL,  // full reverse duty on pin one
        MODE_REV_DIV,   // scaled reverse duty on pin one
        MODE_FWD_FULL,  // full forward duty on pin two
        MODE_FWD_DIV    // scaled forward duty on pin two
    } mode_t;

    // Work carried by one channel through the divider stages.
    typedef struct packed {
        mode_t                  mode;
        width_t                 span;
        logic [REM_BITS-1:0]    rem;
        logic [QUOT_BITS-1:0]   quot;
    } lane_t;

    typedef struct packed {
        duty_t pin1;
        duty_t pin2;
    } pins_t;

    // Places the width against the dead band and sets up the division.
    function automatic lane_t lane_decode(width_t w, width_t pmin, width_t pmax,
                                          width_t dlo, width_t dhi);
        lane_t x;
        x.mode = MODE_IDLE;
        x.span = '0;
        x.rem  = '0;
        x.quot = '0;
        if (w >= dlo && w <= dhi) begin
            x.mode = MODE_IDLE;
        end else if (w < dlo) begin
            // At or below the reverse end of the range the duty saturates high.
            if (dlo <= pmin || w < pmin) begin
                x.mode = MODE_REV_FULL;
            end else begin
                x.mode = MODE_REV_DIV;
                x.span = dlo - pmin;
                x.rem  = REM_BITS'(w - pmin);
            end
        end else begin
            if (pmax <= dhi) begin
                x.mode = MODE_FWD_FULL;
            end else begin
                x.mode = MODE_FWD_DIV;
                x.span = pmax - dhi;
                x.rem  = REM_BITS'(w - dhi);
            end
        end
        return x;
    endfunction

    // Multiplies the distance by DUTY_MAX, which is all ones: d * 2^n - d.
    function automatic lane_t lane_scale(lane_t x);
        lane_t y;
        y = x;
        y.rem = {x.rem[WIDTH_BITS-1:0], {DUTY_BITS{1'b0}}} - x.rem;
        return y;
    endfunction

    // One restoring division step producing quotient bit b.
    function automatic lane_t lane_div_step(lane_t x, int b);
        lane_t               y;
        logic [REM_BITS-1:0] trial;
        y = x;
        trial = REM_BITS'(x.span) << b;
        if (x.rem >= trial) begin
            y.rem     = x.rem - trial;
            y.quot[b] = 1'b1;
        end
        return y;
    endfunction

    // Turns the finished quotient into the two pin duties.
    function automatic pins_t lane_pins(lane_t x);
        pins_t p;
        p.pin1 = '0;
        p.pin2 = '0;
        case (x.mode)
            MODE_REV_FULL: p.pin1 = DUTY_MAX;
            // Below the band the quotient stays under DUTY_MAX, so no clamp is needed.
            MODE_REV_DIV:  p.pin1 = DUTY_MAX - x.quot[DUTY_BITS-1:0];
            MODE_FWD_FULL: p.pin2 = DUTY_MAX;
            MODE_FWD_DIV:  p.pin2 = x.quot[DUTY_BITS] ? DUTY_MAX : x.quot[DUTY_BITS-1:0];
            default: begin
                p.pin1 = '0;
                p.pin2 = '0;
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### src/rc_pulse_to_hbridge_duty.sv
`default_nettype none

// Channel    | Direction | Handshake            | Payload
// -----------+-----------+----------------------+--------------------------------------
// s_ (input) | in        | s_valid / s_ready    | s_width_a, s_width_b
// m_ (result)| out       | m_valid / m_ready    | m_a_pin1_duty .. m_b_pin2_duty
// cfg_       | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item can enter every cycle unless m_ready stalls the output; m_valid is registered.
// The restoring divider resolves one quotient bit per stage.
// Reset (aresetn low, synchronous) empties the pipeline and loads the default
// calibration. A stall on m_ready freezes every stage, so nothing is lost or
// repeated, and s_ready stays high as long as the output register can move.
module rc_pulse_to_hbridge_duty
    import rcpd_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,

    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [WIDTH_BITS-1:0] s_width_a,
    input  wire  [WIDTH_BITS-1:0] s_width_b,

    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [DUTY_BITS-1:0]  m_a_pin1_duty,
    output logic [DUTY_BITS-1:0]  m_a_pin2_duty,
    output logic [DUTY_BITS-1:0]  m_b_pin1_duty,
    output logic [DUTY_BITS-1:0]  m_b_pin2_duty,

    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [INDEX_BITS-1:0] cfg_index,
    input  wire  [WIDTH_BITS-1:0] cfg_data
);

    // Stage 0 places the width against the band, stage 1 scales it by the full
    // duty, and the remaining stages each resolve one quotient bit, top bit first.
    localparam int NUM_STAGES = QUOT_BITS + 2;
    localparam int LAST       = NUM_STAGES - 1;

    width_t cal_reg [NUM_REGS];

    lane_t  lane_reg  [NUM_STAGES][NUM_CHANNELS];
    lane_t  lane_next [NUM_STAGES][NUM_CHANNELS];
    logic   valid_reg [NUM_STAGES];

    pins_t  pins_next [NUM_CHANNELS];
    pins_t  pins_reg  [NUM_CHANNELS];
    logic   m_valid_reg;

    logic   advance;
    width_t width_in [NUM_CHANNELS];

    // The whole pipeline moves together whenever the output register is free or being read.
    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    assign width_in[CH_A] = s_width_a;
    assign width_in[CH_B] = s_width_b;

    // Calibration registers. Users write only while the pipeline is empty; not enforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cal_reg[i] <= CAL_RESET[i];
            end
        end else if (cfg_valid && cfg_ready) begin
            cal_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            lane_next[0][c] = lane_decode(width_in[c],
                cal_reg[c*REGS_PER_CH + OFS_PULSE_MIN],
                cal_reg[c*REGS_PER_CH + OFS_PULSE_MAX],
                cal_reg[c*REGS_PER_CH + OFS_DEAD_LOW],
                cal_reg[c*REGS_PER_CH + OFS_DEAD_HIGH]);
            lane_next[1][c] = lane_scale(lane_reg[0][c]);
            for (int s = 2; s < NUM_STAGES; s++) begin
                // Stage s resolves quotient bit QUOT_BITS + 1 - s.
                lane_next[s][c] = lane_div_step(lane_reg[s-1][c], QUOT_BITS + 1 - s);
            end
            pins_next[c] = lane_pins(lane_reg[LAST][c]);
        end
    end

    // Valid bits travel alongside the lanes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                valid_reg[s] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg[0] <= s_valid;
            for (int s = 1; s < NUM_STAGES; s++) begin
                valid_reg[s] <= valid_reg[s-1];
            end
            m_valid_reg <= valid_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    lane_reg[s][c] <= lane_next[s][c];
                end
            end
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                pins_reg[c] <= pins_next[c];
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_a_pin1_duty = pins_reg[CH_A].pin1;
    assign m_a_pin2_duty = pins_reg[CH_A].pin2;
    assign m_b_pin1_duty = pins_reg[CH_B].pin1;
    assign m_b_pin2_duty = pins_reg[CH_B].pin2;

endmodule

`default_nettype wire

### tb/rc_pulse_to_hbridge_duty_test.sv
`timescale 1ns / 1ps

module rc_pulse_to_hbridge_duty_test;
    import rcpd_pkg::*;

    // One item on the input channel: a pulse width for each of the two channels.
    typedef struct packed {
        width_t width_a;
        width_t width_b;
    } width_pair_t;

    // One item on the result channel: the four bridge pin duties.
    typedef struct packed {
        duty_t a_pin1;
        duty_t a_pin2;
        duty_t b_pin1;
        duty_t b_pin2;
    } bridge_duty_t;

    // Shapes of calibration that the random phases run under.
    typedef enum {
        CAL_TYPICAL,
        CAL_INVERTED,
        CAL_WILD,
        CAL_ZERO,
        CAL_FULL,
        CAL_WIDE
    } cal_kind_t;

    localparam int NUM_PHASES        = 10;
    localparam int PHASE_ITEMS       = 115;
    localparam int PRESSURE_PHASE    = 4;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES      = 20;
    localparam int MAX_REPORTS       = 10;

    logic aclk;
    logic aresetn = 1'b0;

    logic   s_valid   = 1'b0;
    logic   s_ready;
    width_t s_width_a = '0;
    width_t s_width_b = '0;

    logic  m_valid;
    logic  m_ready = 1'b0;
    duty_t m_a_pin1_duty;
    duty_t m_a_pin2_duty;
    duty_t m_b_pin1_duty;
    duty_t m_b_pin2_duty;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [INDEX_BITS-1:0] cfg_index = '0;
    width_t                cfg_data  = '0;

    // The testbench's own copy of the calibration registers, starting from the
    // documented power-up values and following every accepted register write.
    width_t cal [NUM_REGS] = '{
        16'd1131, 16'd2030, 16'd1479, 16'd1485,
        16'd970,  16'd1850, 16'd1479, 16'd1485
    };

    // Items waiting to be offered, and duties waiting to come out, oldest first.
    width_pair_t  pending_widths  [$];
    bridge_duty_t expected_duties [$];

    int widths_queued   = 0;
    int duties_received = 0;
    int mismatch_count  = 0;

    // Percent chance per cycle that the sender idles and that the receiver stalls.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // The long receiver hold-off is started once from the main sequence.
    logic pressure_armed = 1'b0;
    logic hold_off       = 1'b0;

    string duty_names [4] = '{"a_pin1_duty", "a_pin2_duty", "b_pin1_duty", "b_pin2_duty"};

    rc_pulse_to_hbridge_duty dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_width_a     (s_width_a),
        .s_width_b     (s_width_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_a_pin1_duty (m_a_pin1_duty),
        .m_a_pin2_duty (m_a_pin2_duty),
        .m_b_pin1_duty (m_b_pin1_duty),
        .m_b_pin2_duty (m_b_pin2_duty),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Floor division for a positive divisor, rounding toward minus infinity
    // so that widths below pulse_min push the reverse duty past full scale.
    function automatic longint floor_div(longint num, longint den);
        if (num >= 0) begin
            return num / den;
        end
        return -((-num + den - 1) / den);
    endfunction

    function automatic duty_t saturate_duty(longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > longint'(DUTY_MAX)) begin
            return DUTY_MAX;
        end
        return duty_t'(v);
    endfunction

    // Duties of the two pins of one bridge for one pulse width.
    function automatic void channel_duty(input width_t w, input int ch,
                                         output duty_t pin1, output duty_t pin2);
        longint wi, pmin, pmax, dlo, dhi, span;
        int     base;
        base = ch * REGS_PER_CH;
        wi   = w;
        pmin = cal[base + OFS_PULSE_MIN];
        pmax = cal[base + OFS_PULSE_MAX];
        dlo  = cal[base + OFS_DEAD_LOW];
        dhi  = cal[base + OFS_DEAD_HIGH];
        pin1 = '0;
        pin2 = '0;
        if (wi >= dlo && wi <= dhi) begin
            // Inside the dead band the motor coasts with both pins low.
            return;
        end
        if (wi < dlo) begin
            // Reverse: a span of zero or less means full duty right away.
            span = dlo - pmin;
            if (span <= 0) begin
                pin1 = DUTY_MAX;
            end else begin
                pin1 = saturate_duty(longint'(DUTY_MAX)
                                     - floor_div((wi - pmin) * longint'(DUTY_MAX), span));
            end
        end else begin
            // Forward, which also covers any width of an inverted band that is
            // not below dead_low.
            span = pmax - dhi;
            if (span <= 0) begin
                pin2 = DUTY_MAX;
            end else begin
                pin2 = saturate_duty(floor_div((wi - dhi) * longint'(DUTY_MAX), span));
            end
        end
    endfunction

    function automatic bridge_duty_t bridge_duties(width_t wa, width_t wb);
        bridge_duty_t d;
        channel_duty(wa, CH_A, d.a_pin1, d.a_pin2);
        channel_duty(wb, CH_B, d.b_pin1, d.b_pin2);
        return d;
    endfunction

    function automatic width_t clamp_width(int v);
        if (v < 0) begin
            return '0;
        end
        if (v > 65535) begin
            return '1;
        end
        return width_t'(v);
    endfunction

    // Random width for one channel. Most widths fall across the calibrated range,
    // a good share sits within a few microseconds of one of the four register
    // values, and the rest is spread over the whole field so every bit toggles.
    function automatic width_t pick_width(int ch);
        int base, lo, hi, roll, c;
        base = ch * REGS_PER_CH;
        lo   = int'(cal[base]);
        hi   = lo;
        for (int i = 1; i < REGS_PER_CH; i++) begin
            if (int'(cal[base + i]) < lo) lo = int'(cal[base + i]);
            if (int'(cal[base + i]) > hi) hi = int'(cal[base + i]);
        end
        roll = $urandom_range(99, 0);
        if (roll < 60) begin
            return width_t'($urandom_range(int'(clamp_width(hi + 64)),
                                           int'(clamp_width(lo - 64))));
        end
        if (roll < 85) begin
            c = int'(cal[base + $urandom_range(REGS_PER_CH - 1, 0)])
                + int'($urandom_range(6, 0)) - 3;
            return clamp_width(c);
        end
        return width_t'($urandom_range(65535, 0));
    endfunction

    task automatic push_widths(input width_t wa, input width_t wb);
        pending_widths.push_back('{width_a: wa, width_b: wb});
        widths_queued++;
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Writes all eight calibration registers in index order, one item per
    // handshake. Called on a clock edge, and returns on one.
    task automatic write_cal(input width_t v [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= INDEX_BITS'(i);
            cfg_data  <= v[i];
            do @(posedge aclk); while (!cfg_ready);
            cal[i] = v[i];
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Builds a calibration set for both channels.
    task automatic pick_cal(input cal_kind_t kind, output width_t v [NUM_REGS]);
        int pmin, pmax, dlo, dhi, base;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            base = ch * REGS_PER_CH;
            pmin = $urandom_range(1200, 800);
            dlo  = pmin + $urandom_range(600, 1);
            dhi  = dlo + $urandom_range(40, 0);
            pmax = dhi + $urandom_range(700, 1);
            case (kind)
                CAL_INVERTED: begin
                    dlo = pmin + $urandom_range(600, 41);
                    dhi = dlo - $urandom_range(40, 1);
                end
                CAL_WILD: begin
                    pmin = $urandom_range(65535, 0);
                    pmax = $urandom_range(65535, 0);
                    dlo  = $urandom_range(65535, 0);
                    dhi  = $urandom_range(65535, 0);
                end
                CAL_ZERO: begin
                    pmin = 0;
                    pmax = 0;
                    dlo  = 0;
                    dhi  = 0;
                end
                CAL_FULL: begin
                    pmin = 65535;
                    pmax = 65535;
                    dlo  = 65535;
                    dhi  = 65535;
                end
                CAL_WIDE: begin
                    pmin = 0;
                    pmax = 65535;
                    dlo  = 32767;
                    dhi  = 32768;
                end
                default: begin
                end
            endcase
            v[base + OFS_PULSE_MIN] = width_t'(pmin);
            v[base + OFS_PULSE_MAX] = width_t'(pmax);
            v[base + OFS_DEAD_LOW]  = width_t'(dlo);
            v[base + OFS_DEAD_HIGH] = width_t'(dhi);
        end
    endtask

    // Returns once every queued item has come back as a result.
    task automatic wait_drained();
        do @(posedge aclk); while (duties_received < widths_queued);
    endtask

    // Sender. The payload stays on the ports until the item is taken, and the
    // prediction is made from those same ports on the edge that takes it.
    always @(posedge aclk) begin
        width_pair_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_duties.push_back(bridge_duties(s_width_a, s_width_b));
            end
            if (!s_valid || s_ready) begin
                if (pending_widths.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    next_item = pending_widths.pop_front();
                    s_valid   <= 1'b1;
                    s_width_a <= next_item.width_a;
                    s_width_b <= next_item.width_b;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every result taken is checked field by field against the
    // oldest prediction; a result with nothing predicted is a failure too.
    always @(posedge aclk) begin
        bridge_duty_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_off && ($urandom_range(99, 0) >= stall_pct);
            if (m_valid && m_ready) begin
                duties_received++;
                got = '{m_a_pin1_duty, m_a_pin2_duty, m_b_pin1_duty, m_b_pin2_duty};
                if (expected_duties.size() == 0) begin
                    note_mismatch("unexpected result, packed duties", 0, int'(got));
                end else begin
                    want = expected_duties.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (got[31 - 8 * i -: 8] !== want[31 - 8 * i -: 8]) begin
                            note_mismatch(duty_names[i], int'(want[31 - 8 * i -: 8]),
                                          int'(got[31 - 8 * i -: 8]));
                        end
                    end
                end
            end
        end
    end

    // Long receiver hold-off. The sender keeps offering items meanwhile, so the
    // pipeline fills up and the block has to push back on its input.
    initial begin : receiver_hold_off
        wait (pressure_armed);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (LONG_STALL_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #6_000_000;
        $display("rc_pulse_to_hbridge_duty verification failed");
        $finish;
    end

    initial begin
        width_t    special [NUM_REGS];
        width_t    next_cal [NUM_REGS];
        cal_kind_t phase_cal [NUM_PHASES];

        phase_cal = '{CAL_TYPICAL, CAL_WILD, CAL_FULL, CAL_ZERO, CAL_WIDE,
                      CAL_TYPICAL, CAL_INVERTED, CAL_WILD, CAL_TYPICAL, CAL_INVERTED};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items against the power-up calibration: the field extremes,
        // both ends of the full range, each edge of the dead band, a width in
        // the middle of the band, and alternating bit patterns.
        push_widths(16'd0,     16'd0);
        push_widths(16'hFFFF,  16'hFFFF);
        push_widths(16'd1131,  16'd970);
        push_widths(16'd1130,  16'd969);
        push_widths(16'd1300,  16'd1200);
        push_widths(16'd1478,  16'd1478);
        push_widths(16'd1479,  16'd1479);
        push_widths(16'd1482,  16'd1482);
        push_widths(16'd1485,  16'd1485);
        push_widths(16'd1486,  16'd1486);
        push_widths(16'd1700,  16'd1700);
        push_widths(16'd2030,  16'd1850);
        push_widths(16'd2031,  16'd1851);
        push_widths(16'hAAAA,  16'h5555);
        push_widths(16'h5555,  16'hAAAA);
        wait_drained();

        // Channel a gets a zero reverse span and a negative forward span;
        // channel b gets an inverted dead band with no width inside it.
        special = '{16'd1000, 16'd1400, 16'd1000, 16'd1500,
                    16'd1000, 16'd2000, 16'd1600, 16'd1400};
        write_cal(special);
        push_widths(16'd900,   16'd1399);
        push_widths(16'd999,   16'd1400);
        push_widths(16'd1500,  16'd1401);
        push_widths(16'd1501,  16'd1599);
        push_widths(16'd1200,  16'd1600);
        push_widths(16'hFFFF,  16'd0);
        wait_drained();

        // Random phases, each under its own calibration and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            pick_cal(phase_cal[p], next_cal);
            write_cal(next_cal);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_widths(pick_width(CH_A), pick_width(CH_B));
            end
            if (p == PRESSURE_PHASE) begin
                pressure_armed = 1'b1;
            end
            wait_drained();
        end

        // Give any stray extra result time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_duties.size() == 0) begin
            $display("rc_pulse_to_hbridge_duty verification clean");
        end else begin
            $display("rc_pulse_to_hbridge_duty verification failed");
        end
        $finish;
    end

endmodule
